// ----- design/gep_pkg.sv -----
// ----------------------------------------------------------------------------
// gep_pkg: shared definitions of the pivoting linear solver
// Default sizes, register layout and the status types passed between the
// sequencer and the divider chain.
// ----------------------------------------------------------------------------
package gep_pkg;

   // Default sizes of the solver.
   localparam int MAX_ORDER_DEF = 16;
   localparam int FRAC_BITS_DEF = 16;
   localparam int WORD_BITS_DEF = 32;

   // Field widths fixed by the register map and the result format.
   localparam int ORDER_W    = 5;
   localparam int PMIN_W     = 31;
   localparam int INDEX_W    = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Register reset values.
   localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd10;
   localparam logic [PMIN_W-1:0]  PMIN_RESET  = 31'd1;

   // Register indexes, taken from address bit 2.
   localparam logic REG_ORDER = 1'b0;
   localparam logic REG_PMIN  = 1'b1;

   // Control bits that travel along the divider chain with the data.
   typedef struct packed {
      logic valid;
      logic neg;
   } div_ctl_type;

   // Status returned by the divider chain.
   typedef struct packed {
      logic done;
      logic clip;
   } div_status_type;

endpackage

// ----- design/gep_if.sv -----
// ----------------------------------------------------------------------------
// gep_if: handshake channels of the pivoting linear solver
// The coefficient request channel and the solution response channel.
// ----------------------------------------------------------------------------
interface gep_req_if #(
   parameter int WORD_BITS = gep_pkg::WORD_BITS_DEF
);
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] coefficient;

   modport source (output valid, output coefficient, input ready);
   modport sink   (input valid, input coefficient, output ready);
endinterface

interface gep_rsp_if #(
   parameter int WORD_BITS = gep_pkg::WORD_BITS_DEF
);
   import gep_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [INDEX_W-1:0]          unknown_index;
   logic signed [WORD_BITS-1:0] solution;
   logic                        singular;
   logic                        saturated;
   logic                        last;

   modport source (output valid, output unknown_index, output solution,
                   output singular, output saturated, output last, input ready);
   modport sink   (input valid, input unknown_index, input solution,
                   input singular, input saturated, input last, output ready);
endinterface

// ----- design/gauss_elimination_pivot_solver.sv -----
// ----------------------------------------------------------------------------
// gauss_elimination_pivot_solver: fixed-point linear solver, partial pivoting
// Loads an augmented system row by row, eliminates with row pivoting, back
// substitutes and streams out the solution or a single singular result.
// ----------------------------------------------------------------------------
// Loading takes one coefficient per cycle while the solver is in its load
// state, N*(N+1) coefficients for order N. The solve then runs from one
// memory with one write port and a registered read port: the pivot search
// reads and compares each row of a column in turn, each eliminated row costs
// one division through the divider cell row plus a read, a multiply, a
// rounding and a write step per updated element, and each back substitution
// term takes two reads, a multiply, a rounding and a subtract step, with one
// division per unknown. Each result is read from memory and then loaded into
// the output register once that is free. The next system loads while the
// final result still waits in the output register. Row swaps go through a
// row index table and never move data; no memory clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module gauss_elimination_pivot_solver #(
   parameter int MAX_ORDER = gep_pkg::MAX_ORDER_DEF,
   parameter int FRAC_BITS = gep_pkg::FRAC_BITS_DEF,
   parameter int WORD_BITS = gep_pkg::WORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   gep_req_if.sink                         req_bus,
   gep_rsp_if.source                       rsp_bus,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [gep_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [gep_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [gep_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import gep_pkg::*;

   localparam int COLS      = MAX_ORDER + 1;
   localparam int MAT_DEPTH = MAX_ORDER * COLS;
   localparam int MEM_DEPTH = MAT_DEPTH + MAX_ORDER;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int ROW_W     = $clog2(MAX_ORDER);
   localparam int CNT_W     = $clog2(MAX_ORDER + 1);
   localparam int CMP_W     = WORD_BITS + PMIN_W;
   localparam int PROD_W    = 2 * WORD_BITS;

   // Sequencer states.
   localparam int ST_W = 5;
   localparam logic [ST_W-1:0] ST_LOAD  = 5'd0;
   localparam logic [ST_W-1:0] ST_SRD   = 5'd1;
   localparam logic [ST_W-1:0] ST_SCMP  = 5'd2;
   localparam logic [ST_W-1:0] ST_PIVOT = 5'd3;
   localparam logic [ST_W-1:0] ST_EDRD  = 5'd4;
   localparam logic [ST_W-1:0] ST_EDST  = 5'd5;
   localparam logic [ST_W-1:0] ST_EDWT  = 5'd6;
   localparam logic [ST_W-1:0] ST_JRA   = 5'd7;
   localparam logic [ST_W-1:0] ST_JRB   = 5'd8;
   localparam logic [ST_W-1:0] ST_JRND  = 5'd9;
   localparam logic [ST_W-1:0] ST_JWR   = 5'd10;
   localparam logic [ST_W-1:0] ST_BINIT = 5'd11;
   localparam logic [ST_W-1:0] ST_BS    = 5'd12;
   localparam logic [ST_W-1:0] ST_BRA   = 5'd13;
   localparam logic [ST_W-1:0] ST_BRB   = 5'd14;
   localparam logic [ST_W-1:0] ST_BMUL  = 5'd15;
   localparam logic [ST_W-1:0] ST_BRND  = 5'd16;
   localparam logic [ST_W-1:0] ST_BSUB  = 5'd17;
   localparam logic [ST_W-1:0] ST_BDRD  = 5'd18;
   localparam logic [ST_W-1:0] ST_BDST  = 5'd19;
   localparam logic [ST_W-1:0] ST_BDWT  = 5'd20;
   localparam logic [ST_W-1:0] ST_ORD   = 5'd21;
   localparam logic [ST_W-1:0] ST_OLD   = 5'd22;
   localparam logic [ST_W-1:0] ST_SING  = 5'd23;

   // Saturating subtract; the top bit of the result is the clip flag.
   function automatic logic [WORD_BITS:0] sat_sub(input logic signed [WORD_BITS-1:0] a,
                                                  input logic signed [WORD_BITS-1:0] b);
      logic [WORD_BITS:0] d;
      d = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
      if (d[WORD_BITS] != d[WORD_BITS-1]) begin
         return {1'b1, d[WORD_BITS], {(WORD_BITS-1){~d[WORD_BITS]}}};
      end
      return {1'b0, d[WORD_BITS-1:0]};
   endfunction

   // Round half up at the binary point and saturate; top bit is the clip flag.
   function automatic logic [WORD_BITS:0] round_sat(input logic [PROD_W-1:0] p);
      logic signed [PROD_W:0] r;
      logic signed [PROD_W:0] sh;
      logic                   fits;
      r    = $signed({p[PROD_W-1], p}) +
             $signed({{(PROD_W-FRAC_BITS+1){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}});
      sh   = r >>> FRAC_BITS;
      fits = (&sh[PROD_W:WORD_BITS-1]) || !(|sh[PROD_W:WORD_BITS-1]);
      if (!fits) begin
         return {1'b1, sh[PROD_W], {(WORD_BITS-1){~sh[PROD_W]}}};
      end
      return {1'b0, sh[WORD_BITS-1:0]};
   endfunction

   function automatic logic [WORD_BITS-1:0] mag(input logic signed [WORD_BITS-1:0] v);
      return v[WORD_BITS-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [ADDR_W-1:0] maddr(input logic [ROW_W-1:0] row,
                                               input logic [CNT_W-1:0] col);
      return ADDR_W'(ADDR_W'(row) * ADDR_W'(COLS)) + ADDR_W'(col);
   endfunction

   function automatic logic [ADDR_W-1:0] saddr(input logic [ROW_W-1:0] idx);
      return ADDR_W'(MAT_DEPTH) + ADDR_W'(idx);
   endfunction

   // Registers.
   logic [ST_W-1:0]             state_ff, state_in;
   logic [ORDER_W-1:0]          order_ff, order_in;
   logic [PMIN_W-1:0]           pmin_ff, pmin_in;
   logic [ROW_W-1:0]            lrow_ff, lrow_in;
   logic [CNT_W-1:0]            lcol_ff, lcol_in;
   logic [ROW_W-1:0]            k_ff, k_in;
   logic [ROW_W-1:0]            i_ff, i_in;
   logic [CNT_W-1:0]            j_ff, j_in;
   logic [ROW_W-1:0]            cand_ff, cand_in;
   logic [ROW_W-1:0]            kphys_ff, kphys_in;
   logic [WORD_BITS-1:0]        bmag_ff, bmag_in;
   logic [ROW_W-1:0]            bphys_ff, bphys_in;
   logic [ROW_W-1:0]            bidx_ff, bidx_in;
   logic signed [WORD_BITS-1:0] bval_ff, bval_in;
   logic signed [WORD_BITS-1:0] pivot_ff, pivot_in;
   logic signed [WORD_BITS-1:0] f_ff, f_in;
   logic [PROD_W-1:0]           mul_ff, mul_in;
   logic signed [WORD_BITS-1:0] prod_ff, prod_in;
   logic signed [WORD_BITS-1:0] aij_ff, aij_in;
   logic signed [WORD_BITS-1:0] s_ff, s_in;
   logic                        clip_ff, clip_in;
   logic                        rvalid_ff, rvalid_in;
   logic [INDEX_W-1:0]          ridx_ff, ridx_in;
   logic signed [WORD_BITS-1:0] rsol_ff, rsol_in;
   logic                        rsing_ff, rsing_in;
   logic                        rsat_ff, rsat_in;
   logic                        rlast_ff, rlast_in;
   logic [ROW_W-1:0]            perm_ff [MAX_ORDER];

   // Matrix and solution memory.
   logic signed [WORD_BITS-1:0] mem [MEM_DEPTH];
   logic signed [WORD_BITS-1:0] rd_data_ff;
   logic [ADDR_W-1:0]           rd_addr;
   logic                        wr_en;
   logic [ADDR_W-1:0]           wr_addr;
   logic signed [WORD_BITS-1:0] wr_data;

   // Everything else.
   logic [CNT_W-1:0]            n_eff;
   logic [CNT_W-1:0]            nm1;
   logic [CNT_W-1:0]            i_cnt;
   logic [CNT_W-1:0]            k_cnt;
   logic [ROW_W-1:0]            perm_rd;
   logic                        perm_init;
   logic                        perm_swap;
   logic                        req_take;
   logic                        slot_free;
   logic                        csr_write;
   logic [WORD_BITS-1:0]        cur_mag;
   logic                        pivot_small;
   logic signed [WORD_BITS-1:0] mul_a;
   logic [WORD_BITS:0]          rnd;
   logic [WORD_BITS:0]          sub_res;
   logic                        div_start;
   logic signed [WORD_BITS-1:0] div_num;
   logic signed [WORD_BITS-1:0] div_den;
   div_status_type              div_status;
   logic signed [WORD_BITS-1:0] div_quot;

   // Effective order and derived counters.
   always_comb begin
      if (order_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (32'(order_ff) > MAX_ORDER) begin
         n_eff = CNT_W'(MAX_ORDER);
      end else begin
         n_eff = CNT_W'(order_ff);
      end
      nm1   = n_eff - 1'b1;
      i_cnt = CNT_W'(i_ff);
      k_cnt = CNT_W'(k_ff);
   end

   assign perm_rd     = perm_ff[i_ff];
   assign req_take    = req_bus.valid && (state_ff == ST_LOAD);
   assign slot_free   = !rvalid_ff || rsp_bus.ready;
   assign csr_write   = csr_psel && csr_penable && csr_pwrite;
   assign cur_mag     = mag(rd_data_ff);
   assign pivot_small = (bmag_ff == '0) || (CMP_W'(bmag_ff) < CMP_W'(pmin_ff));

   // Shared multiplier, rounding stage and saturating subtractor.
   assign mul_a   = (state_ff == ST_JRB) ? f_ff : aij_ff;
   assign mul_in  = PROD_W'($signed({{WORD_BITS{mul_a[WORD_BITS-1]}}, mul_a}) *
                    $signed({{WORD_BITS{rd_data_ff[WORD_BITS-1]}}, rd_data_ff}));
   assign rnd     = round_sat(mul_ff);
   assign sub_res = sat_sub((state_ff == ST_JWR) ? aij_ff : s_ff, prod_ff);

   // Divider operands.
   assign div_start = (state_ff == ST_EDST) || (state_ff == ST_BDST);
   assign div_num   = (state_ff == ST_EDST) ? rd_data_ff : s_ff;
   assign div_den   = (state_ff == ST_EDST) ? pivot_ff : rd_data_ff;

   gep_div_chain #(
      .WORD_BITS(WORD_BITS),
      .FRAC_BITS(FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .status(div_status),
      .quot  (div_quot)
   );

   // Memory address and write port selection.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = maddr(lrow_ff, lcol_ff);
      wr_data = req_bus.coefficient;
      unique case (state_ff)
         ST_JRA:                   rd_addr = maddr(kphys_ff, j_ff);
         ST_JRB, ST_JRND, ST_BRA:  rd_addr = maddr(perm_rd, j_ff);
         ST_BRB:                   rd_addr = saddr(ROW_W'(j_ff));
         ST_BINIT, ST_BS:          rd_addr = maddr(perm_rd, n_eff);
         ST_BDRD, ST_BDST:         rd_addr = maddr(perm_rd, i_cnt);
         ST_ORD, ST_OLD:           rd_addr = saddr(i_ff);
         default:                  rd_addr = maddr(perm_rd, k_cnt);
      endcase
      if (req_take) begin
         wr_en = 1'b1;
      end else if (state_ff == ST_JWR) begin
         wr_en   = 1'b1;
         wr_addr = maddr(perm_rd, j_ff);
         wr_data = sub_res[WORD_BITS-1:0];
      end else if ((state_ff == ST_BDWT) && div_status.done) begin
         wr_en   = 1'b1;
         wr_addr = saddr(i_ff);
         wr_data = div_quot;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      order_in  = order_ff;
      pmin_in   = pmin_ff;
      lrow_in   = lrow_ff;
      lcol_in   = lcol_ff;
      k_in      = k_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      cand_in   = cand_ff;
      kphys_in  = kphys_ff;
      bmag_in   = bmag_ff;
      bphys_in  = bphys_ff;
      bidx_in   = bidx_ff;
      bval_in   = bval_ff;
      pivot_in  = pivot_ff;
      f_in      = f_ff;
      prod_in   = prod_ff;
      aij_in    = aij_ff;
      s_in      = s_ff;
      clip_in   = clip_ff;
      rvalid_in = rvalid_ff && !rsp_bus.ready;
      ridx_in   = ridx_ff;
      rsol_in   = rsol_ff;
      rsing_in  = rsing_ff;
      rsat_in   = rsat_ff;
      rlast_in  = rlast_ff;
      perm_init = 1'b0;
      perm_swap = 1'b0;

      unique case (state_ff)
         // Store one coefficient; the last one starts the solve.
         ST_LOAD: begin
            if (req_take) begin
               if (lcol_ff == n_eff) begin
                  lcol_in = '0;
                  lrow_in = ROW_W'(lrow_ff + 1'b1);
                  if (CNT_W'(lrow_ff) == nm1) begin
                     lrow_in   = '0;
                     perm_init = 1'b1;
                     k_in      = '0;
                     i_in      = '0;
                     state_in  = ST_SRD;
                  end
               end else begin
                  lcol_in = lcol_ff + 1'b1;
               end
            end
         end
         // Pivot search down column k.
         ST_SRD: begin
            cand_in  = perm_rd;
            state_in = ST_SCMP;
         end
         ST_SCMP: begin
            if (i_ff == k_ff) begin
               kphys_in = cand_ff;
            end
            if ((i_ff == k_ff) || (cur_mag > bmag_ff)) begin
               bmag_in  = cur_mag;
               bphys_in = cand_ff;
               bidx_in  = i_ff;
               bval_in  = rd_data_ff;
            end
            if (i_cnt == nm1) begin
               state_in = ST_PIVOT;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_SRD;
            end
         end
         ST_PIVOT: begin
            if (pivot_small) begin
               state_in = ST_SING;
            end else begin
               perm_swap = (bidx_ff != k_ff);
               kphys_in  = bphys_ff;
               pivot_in  = bval_ff;
               if (k_cnt == nm1) begin
                  i_in     = ROW_W'(nm1);
                  state_in = ST_BINIT;
               end else begin
                  i_in     = k_ff + 1'b1;
                  state_in = ST_EDRD;
               end
            end
         end
         // Elimination factor for row i.
         ST_EDRD: state_in = ST_EDST;
         ST_EDST: begin
            j_in     = k_cnt + 1'b1;
            state_in = ST_EDWT;
         end
         ST_EDWT: begin
            if (div_status.done) begin
               f_in     = div_quot;
               clip_in  = clip_ff || div_status.clip;
               state_in = ST_JRA;
            end
         end
         // Row update, one element at a time.
         ST_JRA: state_in = ST_JRB;
         ST_JRB: state_in = ST_JRND;
         ST_JRND: begin
            prod_in  = rnd[WORD_BITS-1:0];
            clip_in  = clip_ff || rnd[WORD_BITS];
            aij_in   = rd_data_ff;
            state_in = ST_JWR;
         end
         ST_JWR: begin
            clip_in = clip_ff || sub_res[WORD_BITS];
            if (j_ff == n_eff) begin
               if (i_cnt == nm1) begin
                  k_in     = k_ff + 1'b1;
                  i_in     = k_ff + 1'b1;
                  state_in = ST_SRD;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_EDRD;
               end
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = ST_JRA;
            end
         end
         // Back substitution, last unknown first.
         ST_BINIT: state_in = ST_BS;
         ST_BS: begin
            s_in = rd_data_ff;
            j_in = nm1;
            state_in = (i_cnt == nm1) ? ST_BDRD : ST_BRA;
         end
         ST_BRA: state_in = ST_BRB;
         ST_BRB: begin
            aij_in   = rd_data_ff;
            state_in = ST_BMUL;
         end
         ST_BMUL: state_in = ST_BRND;
         ST_BRND: begin
            prod_in  = rnd[WORD_BITS-1:0];
            clip_in  = clip_ff || rnd[WORD_BITS];
            state_in = ST_BSUB;
         end
         ST_BSUB: begin
            s_in    = sub_res[WORD_BITS-1:0];
            clip_in = clip_ff || sub_res[WORD_BITS];
            if (j_ff == i_cnt + 1'b1) begin
               state_in = ST_BDRD;
            end else begin
               j_in     = j_ff - 1'b1;
               state_in = ST_BRA;
            end
         end
         ST_BDRD: state_in = ST_BDST;
         ST_BDST: state_in = ST_BDWT;
         ST_BDWT: begin
            if (div_status.done) begin
               clip_in = clip_ff || div_status.clip;
               if (i_ff == '0) begin
                  state_in = ST_ORD;
               end else begin
                  i_in     = i_ff - 1'b1;
                  state_in = ST_BINIT;
               end
            end
         end
         // Stream the solution out in ascending order.
         ST_ORD: state_in = ST_OLD;
         ST_OLD: begin
            if (slot_free) begin
               rvalid_in = 1'b1;
               ridx_in   = INDEX_W'(i_ff);
               rsol_in   = rd_data_ff;
               rsing_in  = 1'b0;
               rsat_in   = clip_ff;
               rlast_in  = (i_cnt == nm1);
               if (i_cnt == nm1) begin
                  clip_in  = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_ORD;
               end
            end
         end
         ST_SING: begin
            if (slot_free) begin
               rvalid_in = 1'b1;
               ridx_in   = INDEX_W'(k_ff);
               rsol_in   = '0;
               rsing_in  = 1'b1;
               rsat_in   = clip_ff;
               rlast_in  = 1'b1;
               clip_in   = 1'b0;
               state_in  = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase

      // Register writes; a new order drops any partial load.
      if (csr_write) begin
         if (csr_paddr[2] == REG_PMIN) begin
            pmin_in = csr_pwdata[PMIN_W-1:0];
         end else begin
            order_in = csr_pwdata[ORDER_W-1:0];
            lrow_in  = '0;
            lcol_in  = '0;
            clip_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         order_ff  <= ORDER_RESET;
         pmin_ff   <= PMIN_RESET;
         lrow_ff   <= '0;
         lcol_ff   <= '0;
         clip_ff   <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         order_ff  <= order_in;
         pmin_ff   <= pmin_in;
         lrow_ff   <= lrow_in;
         lcol_ff   <= lcol_in;
         clip_ff   <= clip_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      cand_ff  <= cand_in;
      kphys_ff <= kphys_in;
      bmag_ff  <= bmag_in;
      bphys_ff <= bphys_in;
      bidx_ff  <= bidx_in;
      bval_ff  <= bval_in;
      pivot_ff <= pivot_in;
      f_ff     <= f_in;
      mul_ff   <= mul_in;
      prod_ff  <= prod_in;
      aij_ff   <= aij_in;
      s_ff     <= s_in;
      ridx_ff  <= ridx_in;
      rsol_ff  <= rsol_in;
      rsing_ff <= rsing_in;
      rsat_ff  <= rsat_in;
      rlast_ff <= rlast_in;
   end

   // Row index table: identity at solve start, swapped on pivoting.
   always_ff @(posedge clock) begin
      if (perm_init) begin
         for (int r = 0; r < MAX_ORDER; r++) begin
            perm_ff[r] <= ROW_W'(r);
         end
      end else if (perm_swap) begin
         perm_ff[k_ff]    <= bphys_ff;
         perm_ff[bidx_ff] <= kphys_ff;
      end
   end

   // Ports.
   assign req_bus.ready         = (state_ff == ST_LOAD);
   assign rsp_bus.valid         = rvalid_ff;
   assign rsp_bus.unknown_index = ridx_ff;
   assign rsp_bus.solution      = rsol_ff;
   assign rsp_bus.singular      = rsing_ff;
   assign rsp_bus.saturated     = rsat_ff;
   assign rsp_bus.last          = rlast_ff;
   assign csr_pready            = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_PMIN) ? CSR_DATA_W'(pmin_ff)
                                                  : CSR_DATA_W'(order_ff);

endmodule

// ----- design/gep_div_cell.sv -----
// ----------------------------------------------------------------------------
// gep_div_cell: one restoring division step
// Shifts one numerator bit into the partial remainder, subtracts the divisor
// when it fits and shifts the quotient bit in, then hands all to the next cell.
// ----------------------------------------------------------------------------
module gep_div_cell #(
   parameter int WORD_BITS = gep_pkg::WORD_BITS_DEF,
   parameter int NUM_BITS  = gep_pkg::WORD_BITS_DEF + gep_pkg::FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  gep_pkg::div_ctl_type    ctl_i,
   input  logic [WORD_BITS-1:0]    rem_i,
   input  logic [NUM_BITS-1:0]     nq_i,
   input  logic [WORD_BITS-1:0]    den_i,
   output gep_pkg::div_ctl_type    ctl_o,
   output logic [WORD_BITS-1:0]    rem_o,
   output logic [NUM_BITS-1:0]     nq_o,
   output logic [WORD_BITS-1:0]    den_o
);
   import gep_pkg::*;

   div_ctl_type          ctl_ff;
   logic [WORD_BITS-1:0] rem_ff, rem_in;
   logic [NUM_BITS-1:0]  nq_ff, nq_in;
   logic [WORD_BITS-1:0] den_ff;
   logic [WORD_BITS:0]   trial;
   logic [WORD_BITS:0]   diff;
   logic                 fits;

   // Trial subtraction of the divisor from the widened remainder.
   always_comb begin
      trial  = {rem_i, nq_i[NUM_BITS-1]};
      diff   = trial - {1'b0, den_i};
      fits   = (trial >= {1'b0, den_i});
      rem_in = fits ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
      nq_in  = {nq_i[NUM_BITS-2:0], fits};
   end

   // Control resets; data simply follows.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      nq_ff  <= nq_in;
      den_ff <= den_i;
   end

   assign ctl_o = ctl_ff;
   assign rem_o = rem_ff;
   assign nq_o  = nq_ff;
   assign den_o = den_ff;

endmodule

// ----- design/gep_div_chain.sv -----
// ----------------------------------------------------------------------------
// gep_div_chain: fixed-point divider as a row of division cells
// Computes (num * 2^FRAC_BITS) / den truncated toward zero, one quotient bit
// per cell, and saturates the signed result to the word range.
// ----------------------------------------------------------------------------
module gep_div_chain #(
   parameter int WORD_BITS = gep_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = gep_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [WORD_BITS-1:0] num,
   input  logic signed [WORD_BITS-1:0] den,
   output gep_pkg::div_status_type     status,
   output logic signed [WORD_BITS-1:0] quot
);
   import gep_pkg::*;

   localparam int NUM_BITS = WORD_BITS + FRAC_BITS;
   localparam logic [NUM_BITS-1:0] Q_MAX = NUM_BITS'((64'd1 << (WORD_BITS - 1)) - 64'd1);
   localparam logic [NUM_BITS-1:0] Q_MIN_MAG = NUM_BITS'(64'd1 << (WORD_BITS - 1));

   div_ctl_type          ctl  [NUM_BITS+1];
   logic [WORD_BITS-1:0] rem  [NUM_BITS+1];
   logic [NUM_BITS-1:0]  nq   [NUM_BITS+1];
   logic [WORD_BITS-1:0] dv   [NUM_BITS+1];
   logic [WORD_BITS-1:0] num_mag;
   logic [WORD_BITS-1:0] den_mag;

   logic                        done_ff;
   logic                        clip_ff, clip_in;
   logic signed [WORD_BITS-1:0] quot_ff, quot_in;

   // Operand magnitudes and the sign of the quotient.
   always_comb begin
      num_mag = num[WORD_BITS-1] ? (~num + 1'b1) : num;
      den_mag = den[WORD_BITS-1] ? (~den + 1'b1) : den;
      ctl[0].valid = start;
      ctl[0].neg   = num[WORD_BITS-1] ^ den[WORD_BITS-1];
      rem[0] = '0;
      nq[0]  = {num_mag, {FRAC_BITS{1'b0}}};
      dv[0]  = den_mag;
   end

   // The row of division cells.
   for (genvar c = 0; c < NUM_BITS; c++) begin : g_cell
      gep_div_cell #(
         .WORD_BITS(WORD_BITS),
         .NUM_BITS (NUM_BITS)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .ctl_i(ctl[c]),
         .rem_i(rem[c]),
         .nq_i (nq[c]),
         .den_i(dv[c]),
         .ctl_o(ctl[c+1]),
         .rem_o(rem[c+1]),
         .nq_o (nq[c+1]),
         .den_o(dv[c+1])
      );
   end

   // Apply the sign and saturate to the word range.
   always_comb begin
      clip_in = 1'b0;
      if (ctl[NUM_BITS].neg) begin
         if (nq[NUM_BITS] > Q_MIN_MAG) begin
            clip_in = 1'b1;
            quot_in = {1'b1, {(WORD_BITS-1){1'b0}}};
         end else begin
            quot_in = WORD_BITS'(~nq[NUM_BITS] + 1'b1);
         end
      end else if (nq[NUM_BITS] > Q_MAX) begin
         clip_in = 1'b1;
         quot_in = {1'b0, {(WORD_BITS-1){1'b1}}};
      end else begin
         quot_in = WORD_BITS'(nq[NUM_BITS]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= ctl[NUM_BITS].valid;
      end
   end

   always_ff @(posedge clock) begin
      clip_ff <= clip_in;
      quot_ff <= quot_in;
   end

   assign status.done = done_ff;
   assign status.clip = clip_ff;
   assign quot        = quot_ff;

endmodule

// ----- design/gep_checker.sv -----
// ----------------------------------------------------------------------------
// gep_checker: port-level checks of the pivoting linear solver
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
module gep_checker #(
   parameter int WORD_BITS = gep_pkg::WORD_BITS_DEF
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic signed [WORD_BITS-1:0] rsp_solution,
   input logic                        rsp_singular,
   input logic                        rsp_last
);

   // A singular result is always the only one of its solve, with value zero.
   a_singular_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_last && (rsp_solution == '0))
      else $error("singular result not marked last or not zero");

   // While a solve still has results to deliver, no coefficient is taken.
   a_no_load_mid_stream: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("coefficient accepted while results of a solve are pending");

   // No result comes out of reset.
   a_quiet_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_solution))
      else $error("stalled result changed");

endmodule

bind gauss_elimination_pivot_solver gep_checker #(
   .WORD_BITS(WORD_BITS)
) u_gep_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_solution(rsp_bus.solution),
   .rsp_singular(rsp_bus.singular),
   .rsp_last    (rsp_bus.last)
);

// ----- bench/tb_gauss_elimination_pivot_solver.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gauss_elimination_pivot_solver: self-checking bench of the pivoting solver
// Streams augmented systems into the solver through a directed table and then
// random systems of mostly small order. A built-in fixed-point elimination
// predicts every result that the table does not give. Both handshake sides stall at random,
// the register port sets the order from 0 to 6 and walks the threshold through its extremes.
// ----------------------------------------------------------------------------
module tb_gauss_elimination_pivot_solver;
   import gep_pkg::*;

   localparam longint WORD_MAX   = 64'sd2147483647;
   localparam longint WORD_MIN   = -64'sd2147483648;
   localparam logic [2:0] ADDR_ORDER = {REG_ORDER, 2'b00};
   localparam logic [2:0] ADDR_PMIN  = {REG_PMIN, 2'b00};
   localparam int CYCLE_LIMIT = 600000;

   // One solution transaction as seen on the response channel.
   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic signed [31:0] value;
      logic               singular;
      logic               saturated;
      logic               last;
   } solution_type;

   // One row of the directed table: a register write or a coefficient.
   typedef struct packed {
      logic         is_csr;
      logic [2:0]   addr;
      logic [31:0]  data;
      logic         typed;
      solution_type want;
   } step_type;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata, csr_prdata;

   gep_req_if req_bus ();
   gep_rsp_if rsp_bus ();

   gauss_elimination_pivot_solver DUT (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Predictor state: the loaded system, the solution and the registers.
   longint          sys_matrix [16][17];
   longint          sys_solution [16];
   int unsigned     coef_loaded;
   bit              clip_flag;
   logic [4:0]      order_reg;
   logic [30:0]     pmin_reg;
   solution_type    expected_solutions [$];
   int              failures;
   int              results_seen;
   int              cycle_count;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Run time guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic longint clamp_word(longint v);
      if (v > WORD_MAX) begin
         clip_flag = 1'b1;
         return WORD_MAX;
      end
      if (v < WORD_MIN) begin
         clip_flag = 1'b1;
         return WORD_MIN;
      end
      return v;
   endfunction

   // Product rounded half up, then saturated.
   function automatic longint q_mul(longint a, longint b);
      longint p;
      p = a * b + 64'sd32768;
      return clamp_word(p >>> 16);
   endfunction

   // Quotient truncated toward zero, then saturated.
   function automatic longint q_div(longint n, longint d);
      return clamp_word((n * 64'sd65536) / d);
   endfunction

   function automatic longint magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic bit weak_pivot(longint m);
      return (m == 0) || (m < longint'({33'd0, pmin_reg}));
   endfunction

   function automatic int active_order();
      if (order_reg < 1) return 1;
      if (order_reg > 16) return 16;
      return int'(order_reg);
   endfunction

   // Elimination with partial pivoting and back substitution. Returns -1 on
   // success, else the column whose pivot was too small.
   function automatic int eliminate(int n);
      int     p;
      longint best, f, t, s;
      for (int k = 0; k + 1 < n; k++) begin
         p = k;
         best = magnitude(sys_matrix[k][k]);
         for (int i = k + 1; i < n; i++) begin
            if (magnitude(sys_matrix[i][k]) > best) begin
               best = magnitude(sys_matrix[i][k]);
               p = i;
            end
         end
         if (weak_pivot(best)) return k;
         if (p != k) begin
            for (int j = 0; j <= n; j++) begin
               t = sys_matrix[p][j];
               sys_matrix[p][j] = sys_matrix[k][j];
               sys_matrix[k][j] = t;
            end
         end
         for (int i = k + 1; i < n; i++) begin
            f = q_div(sys_matrix[i][k], sys_matrix[k][k]);
            sys_matrix[i][k] = 0;
            for (int j = k + 1; j <= n; j++)
               sys_matrix[i][j] = clamp_word(sys_matrix[i][j] - q_mul(f, sys_matrix[k][j]));
         end
      end
      if (weak_pivot(magnitude(sys_matrix[n-1][n-1]))) return n - 1;
      for (int i = n - 1; i >= 0; i--) begin
         s = sys_matrix[i][n];
         for (int j = n - 1; j > i; j--)
            s = clamp_word(s - q_mul(sys_matrix[i][j], sys_solution[j]));
         sys_solution[i] = q_div(s, sys_matrix[i][i]);
      end
      return -1;
   endfunction

   // Stores one coefficient and, on the last one of a system, queues the
   // solution. A typed expectation replaces the predicted one when given.
   task automatic absorb_coefficient(logic signed [31:0] c, bit typed, solution_type want);
      int           n;
      int           col;
      solution_type r;
      n = active_order();
      if (coef_loaded >= n * (n + 1)) coef_loaded = 0;
      sys_matrix[coef_loaded / (n + 1)][coef_loaded % (n + 1)] = longint'(c);
      coef_loaded++;
      if (coef_loaded < n * (n + 1)) return;
      col = eliminate(n);
      coef_loaded = 0;
      if (typed) begin
         expected_solutions.push_back(want);
      end else if (col >= 0) begin
         r = '{INDEX_W'(col), 32'sd0, 1'b1, clip_flag, 1'b1};
         expected_solutions.push_back(r);
      end else begin
         for (int i = 0; i < n; i++) begin
            r = '{INDEX_W'(i), sys_solution[i][31:0], 1'b0, clip_flag, 1'b1 * (i == n - 1)};
            expected_solutions.push_back(r);
         end
      end
      clip_flag = 1'b0;
   endtask

   // Offers one coefficient after a random gap; valid stays high when the
   // next transaction follows without a gap.
   task automatic send_coefficient(logic [31:0] c, bit typed, solution_type want);
      int gap;
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.coefficient <= c;
      do @(posedge clock); while (!req_bus.ready);
      absorb_coefficient(c, typed, want);
      @(negedge clock);
   endtask

   // Waits until the solver is idle, then gives the load path time to settle.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (expected_solutions.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_ORDER) begin
         order_reg   = data[4:0];
         coef_loaded = 0;
         clip_flag   = 1'b0;
      end else begin
         pmin_reg = data[30:0];
      end
   endtask

   // Random coefficient of one of several system flavors.
   function automatic logic [31:0] random_coefficient(int flavor, int row, int col, int n);
      logic [31:0] v;
      case (flavor)
         0: begin
            if (col == row) v = $urandom_range(32'h80000, 32'h200000);
            else if (col == n) v = $urandom_range(0, 32'h100000);
            else v = $urandom_range(0, 32'h40000);
            if ($urandom_range(0, 1)) v = -v;
         end
         1: v = $urandom;
         2: v = ($urandom_range(0, 6) - 3) << 16;
         default: begin
            v = $urandom_range(32'h70000000, 32'h7FFFFFFF);
            if ($urandom_range(0, 1)) v = -v;
         end
      endcase
      return v;
   endfunction

   // Response side: random stalls, one long hold-off, and the field checks.
   initial begin
      int           gap;
      bit           busy;
      bit           held;
      solution_type want;
      busy = 1'b1;
      held = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (results_seen % 24 == 0) busy = $urandom_range(0, 1);
         gap = busy ? $urandom_range(0, 4) : 0;
         // One long hold-off while the sender is still offering coefficients.
         if (!held && (results_seen >= 40) && req_bus.valid) begin
            gap  = 600;
            held = 1'b1;
         end
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         results_seen++;
         if (expected_solutions.size() == 0) begin
            $error("unexpected solution transaction, index %0d", rsp_bus.unknown_index);
            failures++;
         end else begin
            want = expected_solutions.pop_front();
            if (rsp_bus.unknown_index !== want.index) begin
               $error("unknown_index: expected %0d got %0d", want.index,
                      rsp_bus.unknown_index);
               failures++;
            end
            if (rsp_bus.solution !== want.value) begin
               $error("solution: expected %08h got %08h", want.value, rsp_bus.solution);
               failures++;
            end
            if (rsp_bus.singular !== want.singular) begin
               $error("singular: expected %0b got %0b", want.singular, rsp_bus.singular);
               failures++;
            end
            if (rsp_bus.saturated !== want.saturated) begin
               $error("saturated: expected %0b got %0b", want.saturated,
                      rsp_bus.saturated);
               failures++;
            end
            if (rsp_bus.last !== want.last) begin
               $error("last: expected %0b got %0b", want.last, rsp_bus.last);
               failures++;
            end
         end
         @(negedge clock);
      end
   end

   // Directed table: single unknowns with typed results, then pivoting cases.
   step_type steps [] = '{
      '{1'b1, ADDR_ORDER, 32'd0, 1'b0, '0},
      '{1'b0, 3'd0, 32'h00010000, 1'b0, '0},
      '{1'b0, 3'd0, 32'h00020000, 1'b1, '{4'd0, 32'sh00020000, 1'b0, 1'b0, 1'b1}},
      '{1'b0, 3'd0, 32'h00000000, 1'b0, '0},
      '{1'b0, 3'd0, 32'h00000005, 1'b1, '{4'd0, 32'sd0, 1'b1, 1'b0, 1'b1}},
      '{1'b0, 3'd0, 32'hFFFFFFFF, 1'b0, '0},
      '{1'b0, 3'd0, 32'h80000000, 1'b1, '{4'd0, 32'sh7FFFFFFF, 1'b0, 1'b1, 1'b1}},
      '{1'b1, ADDR_PMIN, 32'h7FFFFFFF, 1'b0, '0},
      '{1'b0, 3'd0, 32'h00010000, 1'b0, '0},
      '{1'b0, 3'd0, 32'h00010000, 1'b1, '{4'd0, 32'sd0, 1'b1, 1'b0, 1'b1}},
      '{1'b1, ADDR_PMIN, 32'd0, 1'b0, '0},
      '{1'b0, 3'd0, 32'h00000000, 1'b0, '0},
      '{1'b0, 3'd0, 32'h7FFFFFFF, 1'b1, '{4'd0, 32'sd0, 1'b1, 1'b0, 1'b1}},
      '{1'b1, ADDR_PMIN, 32'd1, 1'b0, '0},
      '{1'b1, ADDR_ORDER, 32'd2, 1'b0, '0},
      // A partial load, thrown away by rewriting the order.
      '{1'b0, 3'd0, 32'h00050000, 1'b0, '0},
      '{1'b1, ADDR_ORDER, 32'd2, 1'b0, '0},
      // The second row has the larger pivot, so the rows swap.
      '{1'b0, 3'd0, 32'h00010000, 1'b0, '0},
      '{1'b0, 3'd0, 32'h00020000, 1'b0, '0},
      '{1'b0, 3'd0, 32'h00030000, 1'b0, '0},
      '{1'b0, 3'd0, 32'h00040000, 1'b0, '0},
      '{1'b0, 3'd0, 32'h00050000, 1'b0, '0},
      '{1'b0, 3'd0, 32'h00060000, 1'b0, '0},
      // Dependent rows: only the final diagonal is zero.
      '{1'b0, 3'd0, 32'h00010000, 1'b0, '0},
      '{1'b0, 3'd0, 32'h00020000, 1'b0, '0},
      '{1'b0, 3'd0, 32'h00030000, 1'b0, '0},
      '{1'b0, 3'd0, 32'h00020000, 1'b0, '0},
      '{1'b0, 3'd0, 32'h00040000, 1'b0, '0},
      '{1'b0, 3'd0, 32'h00060000, 1'b0, '0},
      // Equal pivot magnitudes: the upper row stays.
      '{1'b0, 3'd0, 32'h00020000, 1'b0, '0},
      '{1'b0, 3'd0, 32'h00010000, 1'b0, '0},
      '{1'b0, 3'd0, 32'h00050000, 1'b0, '0},
      '{1'b0, 3'd0, 32'hFFFE0000, 1'b0, '0},
      '{1'b0, 3'd0, 32'h00030000, 1'b0, '0},
      '{1'b0, 3'd0, 32'h00010000, 1'b0, '0}
   };

   // Main sequence.
   initial begin
      int        n, flavor, systems, random_items;
      logic [4:0] ord;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.coefficient = '0;
      rsp_bus.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      failures = 0;
      results_seen = 0;
      cycle_count = 0;
      coef_loaded = 0;
      clip_flag = 1'b0;
      order_reg = ORDER_RESET;
      pmin_reg = PMIN_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (steps[i]) begin
         if (steps[i].is_csr) begin
            settle();
            csr_write(steps[i].addr, steps[i].data);
         end else begin
            send_coefficient(steps[i].data, steps[i].typed, steps[i].want);
         end
      end

      // Random phases of small order, a few systems each.
      random_items = 0;
      while (random_items < 190) begin
         settle();
         case ($urandom_range(0, 9))
            0: ord = 5'd0;
            1: ord = 5'($urandom_range(5, 6));
            default: ord = 5'($urandom_range(1, 4));
         endcase
         csr_write(ADDR_ORDER, {27'd0, ord});
         case ($urandom_range(0, 7))
            0: csr_write(ADDR_PMIN, 32'd0);
            1: csr_write(ADDR_PMIN, $urandom_range(0, 32'h8000));
            2: csr_write(ADDR_PMIN, 32'h7FFFFFFF);
            3: csr_write(ADDR_PMIN, 32'd1);
            default: ;
         endcase
         n = active_order();
         systems = $urandom_range(1, 4);
         for (int s = 0; (s < systems) && (random_items < 190); s++) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: flavor = 0;
               6: flavor = 1;
               7, 8: flavor = 2;
               default: flavor = 3;
            endcase
            for (int r = 0; r < n; r++)
               for (int c = 0; c <= n; c++) begin
                  send_coefficient(random_coefficient(flavor, r, c, n), 1'b0, '0);
                  random_items++;
               end
         end
         // Now and then leave a broken system behind before the next write.
         if ($urandom_range(0, 5) == 0) begin
            send_coefficient($urandom, 1'b0, '0);
            random_items++;
         end
      end

      req_bus.valid <= 1'b0;
      while (expected_solutions.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/gep_pkg.sv
design/gep_if.sv
design/gep_div_cell.sv
design/gep_div_chain.sv
design/gauss_elimination_pivot_solver.sv
design/gep_checker.sv
bench/tb_gauss_elimination_pivot_solver.sv
